/* hw/rtl/jse_pkg.sv */
// jse_pkg: shared types, codes, constants and text tables of the JSON stream emitter.
// No dependencies; used through scoped names by every other RTL file of the block but jse_if.sv.
package jse_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int ADDR_W    = $clog2(MAX_DEPTH);
	localparam int LVL_W     = 6;
	localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_DEPTH);

	localparam logic [7:0] C_COMMA  = 8'h2C;
	localparam logic [7:0] C_RBRACK = 8'h5D;
	localparam logic [7:0] C_RBRACE = 8'h7D;

	typedef enum logic [3:0] {
		M_BEGIN_ARR = 4'd0,
		M_END_ARR   = 4'd1,
		M_BEGIN_OBJ = 4'd2,
		M_END_OBJ   = 4'd3,
		M_KEY       = 4'd4,
		M_STR_START = 4'd5,
		M_CHAR      = 4'd6,
		M_STR_END   = 4'd7,
		M_RAW_START = 4'd8,
		M_RAW_BYTE  = 4'd9,
		M_LITERAL   = 4'd10,
		M_CLOSE_TO  = 4'd11,
		M_RESET     = 4'd12
	} mode_t;

	typedef enum logic [2:0] {
		CS_EMPTY = 3'd0,
		CS_FIN   = 3'd1,
		CS_ARR_E = 3'd2,
		CS_ARR_N = 3'd3,
		CS_OBJ_E = 3'd4,
		CS_OBJ_N = 3'd5,
		CS_OBJ_K = 3'd6
	} cstate_t;

	typedef enum logic [1:0] {
		SM_OUT    = 2'd0,
		SM_KEY    = 2'd1,
		SM_STRING = 2'd2,
		SM_RAW    = 2'd3
	} smode_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_VALUE      = 3'd1,
		ERR_NOT_ARRAY  = 3'd2,
		ERR_NOT_OBJECT = 3'd3,
		ERR_OVERFLOW   = 3'd4,
		ERR_STRING     = 3'd5,
		ERR_CLOSE      = 3'd6
	} err_t;

	typedef enum logic [4:0] {
		TK_NONE   = 5'd0,
		TK_DATA   = 5'd1,
		TK_QUOTE  = 5'd2,
		TK_KEYEND = 5'd3,
		TK_LBRACK = 5'd4,
		TK_LBRACE = 5'd5,
		TK_RBRACK = 5'd6,
		TK_RBRACE = 5'd7,
		TK_NULL   = 5'd8,
		TK_TRUE   = 5'd9,
		TK_FALSE  = 5'd10,
		TK_ESC_U0 = 5'd11,
		TK_ESC_R  = 5'd12,
		TK_ESC_N  = 5'd13,
		TK_ESC_T  = 5'd14,
		TK_ESC_Q  = 5'd15,
		TK_ESC_BS = 5'd16
	} tok_t;

	// controller to datapath
	typedef struct packed {
		logic take_en;
		logic capture;
		logic commit;
		logic ct_init;
		logic ct_dec;
		logic ct_final;
		logic ct_fail;
		logic rd_ptr;
		logic emit_load;
		logic pop_load;
		logic pop_upd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic slot_free;
		logic ct_walk;
		logic cs_cont;
		logic rd_cont;
		logic ptr_at_tgt;
		logic emit_last;
		logic pop_last;
	} sts_t;

	function automatic logic is_cont(cstate_t s);
		return (s == CS_ARR_E) || (s == CS_ARR_N) || (s == CS_OBJ_E) || (s == CS_OBJ_N);
	endfunction

	function automatic tok_t esc_tok(logic [7:0] d);
		tok_t t;
		case (d)
			8'h00:   t = TK_ESC_U0;
			8'h0D:   t = TK_ESC_R;
			8'h0A:   t = TK_ESC_N;
			8'h09:   t = TK_ESC_T;
			8'h22:   t = TK_ESC_Q;
			8'h5C:   t = TK_ESC_BS;
			default: t = TK_DATA;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] tok_len(tok_t t);
		logic [2:0] n;
		case (t)
			TK_NONE:   n = 3'd0;
			TK_KEYEND: n = 3'd2;
			TK_NULL:   n = 3'd4;
			TK_TRUE:   n = 3'd4;
			TK_FALSE:  n = 3'd5;
			TK_ESC_U0: n = 3'd6;
			TK_ESC_R:  n = 3'd2;
			TK_ESC_N:  n = 3'd2;
			TK_ESC_T:  n = 3'd2;
			TK_ESC_Q:  n = 3'd2;
			TK_ESC_BS: n = 3'd2;
			default:   n = 3'd1;
		endcase
		return n;
	endfunction

	// text of a token, left aligned, picked by byte index
	function automatic logic [7:0] tok_byte(tok_t t, logic [2:0] idx, logic [7:0] d);
		logic [47:0] text_w;
		logic [47:0] sh;
		case (t)
			TK_DATA:   text_w = {d, 40'h0};
			TK_QUOTE:  text_w = {8'h22, 40'h0};
			TK_KEYEND: text_w = {8'h22, ":", 32'h0};
			TK_LBRACK: text_w = {"[", 40'h0};
			TK_LBRACE: text_w = {"{", 40'h0};
			TK_RBRACK: text_w = {C_RBRACK, 40'h0};
			TK_RBRACE: text_w = {C_RBRACE, 40'h0};
			TK_NULL:   text_w = {"null", 16'h0};
			TK_TRUE:   text_w = {"true", 16'h0};
			TK_FALSE:  text_w = {"false", 8'h0};
			TK_ESC_U0: text_w = {8'h5C, "u0000"};
			TK_ESC_R:  text_w = {8'h5C, "r", 32'h0};
			TK_ESC_N:  text_w = {8'h5C, "n", 32'h0};
			TK_ESC_T:  text_w = {8'h5C, "t", 32'h0};
			TK_ESC_Q:  text_w = {8'h5C, 8'h22, 32'h0};
			TK_ESC_BS: text_w = {8'h5C, 8'h5C, 32'h0};
			default:   text_w = '0;
		endcase
		sh = text_w << {idx, 3'b000};
		return sh[47:40];
	endfunction

endpackage

/* hw/rtl/jse_if.sv */
// jse_in_if / jse_out_if: valid-ready channels for writing events and text bytes.
// Depends on nothing; field widths follow the event and result formats.
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] data_byte;
	logic [5:0] target_level;

	modport source(output valid, mode, data_byte, target_level, input ready);
	modport sink(input valid, mode, data_byte, target_level, output ready);
endinterface

interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic [2:0] error;
	logic [5:0] depth_now;
	logic       finished;

	modport source(output valid, out_byte, byte_valid, last, error, depth_now, finished,
		input ready);
	modport sink(input valid, out_byte, byte_valid, last, error, depth_now, finished,
		output ready);
endinterface

/* hw/rtl/jse_datapath.sv */
// jse_datapath: writer state, container stack memory, event decode, text expansion
// and output register. Depends on jse_pkg and the channel interfaces in jse_if.sv.
module jse_datapath (
	input  logic          clk,
	input  logic          arst_n,
	jse_in_if.sink        evt,
	jse_out_if.source     txt,
	input  jse_pkg::cmd_t cmd,
	output jse_pkg::sts_t sts
);

	logic [3:0]                   mode_q;
	logic [7:0]                   data_q;
	logic [jse_pkg::LVL_W-1:0]    tgt_q;

	jse_pkg::cstate_t             cs_q;
	jse_pkg::smode_t              sm_q;
	logic [jse_pkg::LVL_W-1:0]    lvl_q;
	logic [jse_pkg::LVL_W-1:0]    ptr_q;

	jse_pkg::cstate_t             stack_mem [jse_pkg::MAX_DEPTH];
	jse_pkg::cstate_t             rd_q;
	logic [jse_pkg::ADDR_W-1:0]   rd_addr;

	jse_pkg::err_t                err_q;
	logic [jse_pkg::LVL_W-1:0]    dnow_q;
	logic                         fin_q;
	logic                         comma_q;
	jse_pkg::tok_t                tok_q;
	logic [2:0]                   idx_q;

	logic                         ov_q;
	logic [7:0]                   ob_q;
	logic                         bv_q;
	logic                         last_q;
	jse_pkg::err_t                oerr_q;
	logic [jse_pkg::LVL_W-1:0]    odep_q;
	logic                         ofin_q;

	logic                         vok;
	logic                         vcomma;
	jse_pkg::cstate_t             vns;
	logic [jse_pkg::LVL_W-1:0]    lvl_dec;

	jse_pkg::err_t                e_err;
	logic                         e_comma;
	jse_pkg::tok_t                e_tok;
	jse_pkg::cstate_t             e_ncs;
	jse_pkg::smode_t              e_nsm;
	logic [jse_pkg::LVL_W-1:0]    e_nlvl;
	logic                         e_push;

	logic [2:0]                   n_bytes;
	logic [7:0]                   cur_byte;
	logic                         emit_last;
	logic                         pop_last;

	assign lvl_dec = lvl_q - jse_pkg::LVL_W'(1);

	// state after one more value at this level
	always_comb begin
		vok    = 1'b1;
		vcomma = 1'b0;
		vns    = cs_q;
		case (cs_q)
			jse_pkg::CS_EMPTY: vns = jse_pkg::CS_FIN;
			jse_pkg::CS_ARR_E: vns = jse_pkg::CS_ARR_N;
			jse_pkg::CS_ARR_N: begin
				vns    = jse_pkg::CS_ARR_N;
				vcomma = 1'b1;
			end
			jse_pkg::CS_OBJ_K: vns = jse_pkg::CS_OBJ_N;
			default:           vok = 1'b0;
		endcase
	end

	// event decode against the current state
	always_comb begin
		e_err   = jse_pkg::ERR_OK;
		e_comma = 1'b0;
		e_tok   = jse_pkg::TK_NONE;
		e_ncs   = cs_q;
		e_nsm   = sm_q;
		e_nlvl  = lvl_q;
		e_push  = 1'b0;
		case (mode_q)
			jse_pkg::M_BEGIN_ARR, jse_pkg::M_BEGIN_OBJ: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if (!vok) begin
					e_err = jse_pkg::ERR_VALUE;
				end else if (lvl_q >= jse_pkg::MAX_LVL) begin
					e_err = jse_pkg::ERR_OVERFLOW;
				end else begin
					e_comma = vcomma;
					e_push  = 1'b1;
					e_nlvl  = lvl_q + jse_pkg::LVL_W'(1);
					if (mode_q == jse_pkg::M_BEGIN_ARR) begin
						e_tok = jse_pkg::TK_LBRACK;
						e_ncs = jse_pkg::CS_ARR_E;
					end else begin
						e_tok = jse_pkg::TK_LBRACE;
						e_ncs = jse_pkg::CS_OBJ_E;
					end
				end
			end
			jse_pkg::M_END_ARR: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if ((cs_q != jse_pkg::CS_ARR_E && cs_q != jse_pkg::CS_ARR_N)
						|| lvl_q == '0) begin
					e_err = jse_pkg::ERR_NOT_ARRAY;
				end else begin
					e_tok  = jse_pkg::TK_RBRACK;
					e_nlvl = lvl_dec;
					e_ncs  = rd_q;
				end
			end
			jse_pkg::M_END_OBJ: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if ((cs_q != jse_pkg::CS_OBJ_E && cs_q != jse_pkg::CS_OBJ_N)
						|| lvl_q == '0) begin
					e_err = jse_pkg::ERR_NOT_OBJECT;
				end else begin
					e_tok  = jse_pkg::TK_RBRACE;
					e_nlvl = lvl_dec;
					e_ncs  = rd_q;
				end
			end
			jse_pkg::M_KEY: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if (cs_q == jse_pkg::CS_OBJ_N || cs_q == jse_pkg::CS_OBJ_E) begin
					e_comma = (cs_q == jse_pkg::CS_OBJ_N);
					e_tok   = jse_pkg::TK_QUOTE;
					e_ncs   = jse_pkg::CS_OBJ_K;
					e_nsm   = jse_pkg::SM_KEY;
				end else begin
					e_err = jse_pkg::ERR_NOT_OBJECT;
				end
			end
			jse_pkg::M_STR_START: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if (!vok) begin
					e_err = jse_pkg::ERR_VALUE;
				end else begin
					e_comma = vcomma;
					e_tok   = jse_pkg::TK_QUOTE;
					e_ncs   = vns;
					e_nsm   = jse_pkg::SM_STRING;
				end
			end
			jse_pkg::M_CHAR: begin
				if (sm_q == jse_pkg::SM_KEY || sm_q == jse_pkg::SM_STRING) begin
					e_tok = jse_pkg::esc_tok(data_q);
				end else begin
					e_err = jse_pkg::ERR_STRING;
				end
			end
			jse_pkg::M_STR_END: begin
				case (sm_q)
					jse_pkg::SM_KEY: begin
						e_tok = jse_pkg::TK_KEYEND;
						e_nsm = jse_pkg::SM_OUT;
					end
					jse_pkg::SM_STRING: begin
						e_tok = jse_pkg::TK_QUOTE;
						e_nsm = jse_pkg::SM_OUT;
					end
					jse_pkg::SM_RAW: e_nsm = jse_pkg::SM_OUT;
					default:         e_err = jse_pkg::ERR_STRING;
				endcase
			end
			jse_pkg::M_RAW_START: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if (!vok) begin
					e_err = jse_pkg::ERR_VALUE;
				end else begin
					e_comma = vcomma;
					e_ncs   = vns;
					e_nsm   = jse_pkg::SM_RAW;
				end
			end
			jse_pkg::M_RAW_BYTE: begin
				if (sm_q != jse_pkg::SM_RAW) e_err = jse_pkg::ERR_STRING;
				else e_tok = jse_pkg::TK_DATA;
			end
			jse_pkg::M_LITERAL: begin
				if (sm_q != jse_pkg::SM_OUT) begin
					e_err = jse_pkg::ERR_STRING;
				end else if (data_q > 8'd2 || !vok) begin
					e_err = jse_pkg::ERR_VALUE;
				end else begin
					e_comma = vcomma;
					e_ncs   = vns;
					if (data_q == 8'd0) e_tok = jse_pkg::TK_NULL;
					else if (data_q == 8'd1) e_tok = jse_pkg::TK_TRUE;
					else e_tok = jse_pkg::TK_FALSE;
				end
			end
			jse_pkg::M_CLOSE_TO: begin
				// a real close walks the stack under the controller
				if (sm_q != jse_pkg::SM_OUT) e_err = jse_pkg::ERR_STRING;
			end
			jse_pkg::M_RESET: begin
				e_ncs  = jse_pkg::CS_EMPTY;
				e_nsm  = jse_pkg::SM_OUT;
				e_nlvl = '0;
			end
			default: ;
		endcase
	end

	// text expansion of the registered plan
	assign n_bytes   = {2'b00, comma_q} + jse_pkg::tok_len(tok_q);
	assign emit_last = (n_bytes == 3'd0) || (idx_q == n_bytes - 3'd1);
	assign cur_byte  = (n_bytes == 3'd0) ? 8'h00 :
		(comma_q && idx_q == 3'd0) ? jse_pkg::C_COMMA :
		jse_pkg::tok_byte(tok_q, idx_q - {2'b00, comma_q}, data_q);
	assign pop_last  = (lvl_dec == tgt_q);

	assign rd_addr = cmd.rd_ptr ? ptr_q[jse_pkg::ADDR_W-1:0] : lvl_dec[jse_pkg::ADDR_W-1:0];

	// saved container states, one per open level
	always_ff @(posedge clk) begin
		if (cmd.commit && e_push) begin
			stack_mem[lvl_q[jse_pkg::ADDR_W-1:0]] <= vns;
		end
		rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q  <= jse_pkg::CS_EMPTY;
			sm_q  <= jse_pkg::SM_OUT;
			lvl_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cs_q  <= e_ncs;
				sm_q  <= e_nsm;
				lvl_q <= e_nlvl;
			end else if (cmd.pop_upd) begin
				cs_q  <= rd_q;
				lvl_q <= lvl_dec;
			end
			if (cmd.emit_load || cmd.pop_load) ov_q <= 1'b1;
			else if (txt.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= evt.mode;
			data_q <= evt.data_byte;
			tgt_q  <= evt.target_level;
		end
		if (cmd.commit) begin
			err_q   <= e_err;
			dnow_q  <= e_nlvl;
			fin_q   <= (e_ncs == jse_pkg::CS_FIN);
			comma_q <= e_comma;
			tok_q   <= e_tok;
			idx_q   <= '0;
		end else if (cmd.ct_fail) begin
			err_q   <= jse_pkg::ERR_CLOSE;
			dnow_q  <= lvl_q;
			fin_q   <= (cs_q == jse_pkg::CS_FIN);
			comma_q <= 1'b0;
			tok_q   <= jse_pkg::TK_NONE;
			idx_q   <= '0;
		end else if (cmd.ct_final) begin
			// the level closed down to is known before the first bracket goes out
			err_q  <= jse_pkg::ERR_OK;
			dnow_q <= tgt_q;
			fin_q  <= (rd_q == jse_pkg::CS_FIN);
		end else if (cmd.emit_load) begin
			idx_q <= idx_q + 3'd1;
		end
		if (cmd.ct_init) ptr_q <= lvl_dec;
		else if (cmd.ct_dec) ptr_q <= ptr_q - jse_pkg::LVL_W'(1);
		if (cmd.emit_load) begin
			ob_q   <= cur_byte;
			bv_q   <= (n_bytes != 3'd0);
			last_q <= emit_last;
			oerr_q <= err_q;
			odep_q <= dnow_q;
			ofin_q <= fin_q;
		end else if (cmd.pop_load) begin
			ob_q   <= (cs_q == jse_pkg::CS_ARR_E || cs_q == jse_pkg::CS_ARR_N) ?
				jse_pkg::C_RBRACK : jse_pkg::C_RBRACE;
			bv_q   <= 1'b1;
			last_q <= pop_last;
			oerr_q <= err_q;
			odep_q <= dnow_q;
			ofin_q <= fin_q;
		end
	end

	assign evt.ready = cmd.take_en;

	assign txt.valid      = ov_q;
	assign txt.out_byte   = ob_q;
	assign txt.byte_valid = bv_q;
	assign txt.last       = last_q;
	assign txt.error      = oerr_q;
	assign txt.depth_now  = odep_q;
	assign txt.finished   = ofin_q;

	assign sts.in_valid   = evt.valid;
	assign sts.slot_free  = !ov_q || txt.ready;
	assign sts.ct_walk    = (mode_q == jse_pkg::M_CLOSE_TO) && (sm_q == jse_pkg::SM_OUT)
		&& (tgt_q < lvl_q);
	assign sts.cs_cont    = jse_pkg::is_cont(cs_q);
	assign sts.rd_cont    = jse_pkg::is_cont(rd_q);
	assign sts.ptr_at_tgt = (ptr_q == tgt_q);
	assign sts.emit_last  = emit_last;
	assign sts.pop_last   = pop_last;

endmodule

/* hw/rtl/jse_ctrl.sv */
// jse_ctrl: sequencer of the JSON stream emitter (accept, decode, emit, close walk).
// Depends on jse_pkg for the command and status structs.
module jse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  jse_pkg::sts_t sts,
	output jse_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_EMIT   = 7'b0000100,
		S_CT_RD  = 7'b0001000,
		S_CT_TST = 7'b0010000,
		S_CT_POP = 7'b0100000,
		S_CT_UPD = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.take_en = 1'b1;
				if (sts.in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.ct_walk) begin
					if (sts.cs_cont) begin
						cmd.ct_init = 1'b1;
						state_nxt   = S_CT_RD;
					end else begin
						cmd.ct_fail = 1'b1;
						state_nxt   = S_EMIT;
					end
				end else begin
					cmd.commit = 1'b1;
					state_nxt  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) state_nxt = S_IDLE;
				end
			end
			S_CT_RD: begin
				cmd.rd_ptr = 1'b1;
				state_nxt  = S_CT_TST;
			end
			S_CT_TST: begin
				// last read is the state left behind, the rest must be containers
				if (sts.ptr_at_tgt) begin
					cmd.ct_final = 1'b1;
					state_nxt    = S_CT_POP;
				end else if (!sts.rd_cont) begin
					cmd.ct_fail = 1'b1;
					state_nxt   = S_EMIT;
				end else begin
					cmd.ct_dec = 1'b1;
					state_nxt  = S_CT_RD;
				end
			end
			S_CT_POP: begin
				if (sts.slot_free) begin
					cmd.pop_load = 1'b1;
					state_nxt    = S_CT_UPD;
				end
			end
			S_CT_UPD: begin
				cmd.pop_upd = 1'b1;
				state_nxt   = sts.pop_last ? S_IDLE : S_CT_POP;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/json_stream_emitter_top.sv */
// json_stream_emitter_top: streaming JSON text writer, controller plus datapath.
// Depends on jse_pkg, jse_if.sv, jse_ctrl and jse_datapath.
//
//   channel  dir  handshake      payload
//   evt      in   valid/ready    mode[3:0] data_byte[7:0] target_level[5:0]
//   txt      out  valid/ready    out_byte[7:0] byte_valid last error[2:0]
//                                depth_now[5:0] finished
//
// One event at a time: accepted in S_IDLE, decoded in S_DECODE, then one text beat per
// cycle while txt is free (at least one beat, the most for an escaped NUL).
// close_to walks the stack memory with one read per level (S_CT_RD, S_CT_TST), then
// emits each bracket through S_CT_POP and S_CT_UPD, waiting while txt is stalled.
// arst_n clears the writer state and the output valid flag; the stack needs no clear.
// A stalled txt beat holds in the output register; evt stays not ready meanwhile
// only while the current event still has beats to place.
module json_stream_emitter_top (
	input  logic      clk,
	input  logic      arst_n,
	jse_in_if.sink    evt,
	jse_out_if.source txt
);

	jse_pkg::cmd_t cmd;
	jse_pkg::sts_t sts;

	jse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	jse_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.txt    (txt),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

/* hw/rtl/jse_checker.sv */
// jse_checker: port-level checks on the JSON stream emitter, bound to the top level.
// Depends on jse_pkg for the error codes and on jse_if.sv through the bound port expressions.
module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic       txt_valid,
	input logic       txt_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last,
	input logic [2:0] error,
	input logic [5:0] depth_now,
	input logic       finished
);

	// a waiting beat holds still
	a_txt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |=> txt_valid
		&& $stable({out_byte, byte_valid, last, error, depth_now, finished}))
		else $error("txt beat changed while stalled");

	// an event is decoded before the next one is taken
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("evt ready right after accept");

	// a beat without a byte is the only beat of its event
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !byte_valid |-> last)
		else $error("empty beat not marked last");

	// a rejected event emits no text
	a_err_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && error != jse_pkg::ERR_OK |-> !byte_valid && last)
		else $error("text emitted with an error code");

	// a finished document sits at the top level
	a_fin_depth: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && finished |-> depth_now == 6'd0)
		else $error("finished at nonzero depth");

endmodule

bind json_stream_emitter_top jse_checker u_jse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.evt_valid  (evt.valid),
	.evt_ready  (evt.ready),
	.txt_valid  (txt.valid),
	.txt_ready  (txt.ready),
	.out_byte   (txt.out_byte),
	.byte_valid (txt.byte_valid),
	.last       (txt.last),
	.error      (txt.error),
	.depth_now  (txt.depth_now),
	.finished   (txt.finished)
);
